// ===== rtl/lrgd_pkg.sv =====
// Shared types, codes and helpers for the linear regression trainer.
// Used by lrgd_div and linear_regression_gradient_descent.
`default_nettype none
package lrgd_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned ACC_W    = 64;
    localparam int unsigned LR_W     = 17;
    localparam int unsigned EPOCH_W  = 16;
    localparam int unsigned IDX_W    = 3;   // feature/gradient index, 0..4
    localparam int unsigned BIAS_IDX = 4;   // accumulator slot of the bias
    localparam int unsigned NUM_ACC  = 5;
    localparam int unsigned NUM_W    = 4;
    localparam int unsigned CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_TRAIN = 2'd1,
        ACT_CLEAR = 2'd2
    } t_action;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EPOCH_COUNT   = 2'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EPOCH,
        ST_RD,
        ST_PRED,
        ST_ERR,
        ST_GRAD,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_STEP_MUL,
        ST_STEP_UPD
    } t_state;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        begin
            hi = ACC_W'(64'sh0000_0000_7FFF_FFFF);
            lo = -ACC_W'(64'sh0000_0000_8000_0000);
            if (v > hi) begin
                sat32 = 32'sh7FFF_FFFF;
            end else if (v < lo) begin
                sat32 = 32'sh8000_0000;
            end else begin
                sat32 = v[DATA_W-1:0];
            end
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/lrgd_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module lrgd_ram #(
    parameter int unsigned WIDTH = 160,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_waddr,
    input  wire logic [WIDTH-1:0]                              i_wdata,
    input  wire logic                                          i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_raddr,
    output logic      [WIDTH-1:0]                              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/lrgd_div.sv =====
// Bit-serial divider: grad = sat32(-dividend / divisor), truncating toward zero.
// One quotient bit per cycle. Depends on lrgd_pkg.
`default_nettype none
module lrgd_div #(
    parameter int unsigned DIV_W = 9
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic signed [lrgd_pkg::ACC_W-1:0] i_dividend,
    input  wire logic [DIV_W-1:0]            i_divisor,
    output logic                             o_done,
    output logic signed [lrgd_pkg::DATA_W-1:0] o_grad
);
    localparam int unsigned AW = lrgd_pkg::ACC_W;
    localparam int unsigned CW = $clog2(AW);

    logic             r_busy;
    logic             r_fin;
    logic [CW-1:0]    r_cnt;
    logic [AW-1:0]    r_num;
    logic [AW-1:0]    r_q;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_d;
    logic             r_neg;

    logic [DIV_W:0]   sh;
    logic             qbit;
    logic [DIV_W:0]   diff;

    always_comb begin
        sh   = {r_rem, r_num[AW-1]};
        diff = sh - {1'b0, r_d};
        qbit = (sh >= {1'b0, r_d});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_q    <= '0;
                r_d    <= i_divisor;
                r_neg  <= i_dividend[AW-1];
                r_num  <= i_dividend[AW-1] ? (AW'(0) - i_dividend) : i_dividend;
            end else if (r_busy) begin
                r_rem <= qbit ? diff[DIV_W-1:0] : sh[DIV_W-1:0];
                r_q   <= {r_q[AW-2:0], qbit};
                r_num <= {r_num[AW-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(AW - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                o_done <= 1'b1;
                // negative sum gives a positive gradient
                if (r_neg) begin
                    o_grad <= (r_q > AW'(64'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : r_q[31:0];
                end else begin
                    o_grad <= (r_q > AW'(64'h8000_0000)) ? 32'sh8000_0000
                                                         : (32'd0 - r_q[31:0]);
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/linear_regression_gradient_descent.sv =====
// Full-batch gradient-descent trainer for a linear model, signed Q16.16 with
// saturation. A load transaction (tuser 0) stores one sample unless the store
// is full, when it answers with status full; loads stream at one per cycle
// while the result side keeps up. Clear (tuser 2) and unused codes are also
// answered from the idle state. A train transaction (tuser 1) zeroes weights
// and bias and, on a non-empty store, runs epoch_count epochs; the input side
// is stalled until its result is out. One shared 33x33 multiplier and a
// 64-step serial divider do the arithmetic: each sample is read once from the
// sample RAM and its products go through the multiplier one per cycle, and
// each gradient needs one division.
`default_nettype none
module linear_regression_gradient_descent #(
    parameter int unsigned MAX_SAMPLES = 256,
    parameter int unsigned FEATURES    = 4
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // slave stream
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  wire logic [159:0] i_s_axis_tdata,   // feature_0..feature_3, target
    input  wire logic [1:0]   i_s_axis_tuser,   // action
    // master stream
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    output logic [159:0]      o_m_axis_tdata,   // bias_out, weight_out_0..weight_out_3
    output logic [1:0]        o_m_axis_tuser,   // status
    // configuration
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [16:0]  i_cfg_data
);
    localparam int unsigned DW     = lrgd_pkg::DATA_W;
    localparam int unsigned AW     = lrgd_pkg::ACC_W;
    localparam int unsigned CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int unsigned ADDR_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int unsigned ROW_W  = (FEATURES + 1) * DW;
    localparam int unsigned IW     = lrgd_pkg::IDX_W;

    lrgd_pkg::t_state r_state, n_state;

    logic [lrgd_pkg::LR_W-1:0]    r_lr;
    logic [lrgd_pkg::EPOCH_W-1:0] r_epochs;
    logic [lrgd_pkg::EPOCH_W-1:0] r_ep, n_ep;
    logic [CNT_W-1:0]             r_total, n_total;
    logic [CNT_W-1:0]             r_i, n_i;
    logic [IW-1:0]                r_j, n_j;
    logic signed [AW-1:0]         r_pred, n_pred;
    logic signed [DW-1:0]         r_err, n_err;
    logic signed [AW-1:0]         r_acc [lrgd_pkg::NUM_ACC];
    logic signed [AW-1:0]         n_acc [lrgd_pkg::NUM_ACC];
    logic signed [DW-1:0]         r_w [lrgd_pkg::NUM_W];
    logic signed [DW-1:0]         n_w [lrgd_pkg::NUM_W];
    logic signed [DW-1:0]         r_b, n_b;
    logic signed [AW-1:0]         r_prod;
    logic                         r_out_valid, n_out_valid;
    logic [1:0]                   r_out_status, n_out_status;
    logic [159:0]                 r_out_data, n_out_data;

    logic                 accept;
    logic                 out_load;
    logic [1:0]           out_status;
    logic                 ram_we, ram_re;
    logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
    logic [ROW_W-1:0]     ram_wdata, ram_q;
    logic signed [DW-1:0] x_sel, w_sel, tgt;
    logic signed [DW:0]   mul_a, mul_b;
    logic signed [2*DW+1:0] mul_p;
    logic                 div_start, div_done;
    logic signed [DW-1:0] div_grad;
    logic signed [AW-1:0] div_in;
    logic signed [AW-1:0] step;
    logic signed [DW-1:0] old_v;
    logic signed [DW-1:0] new_v;

    lrgd_ram #(.WIDTH(ROW_W), .DEPTH(MAX_SAMPLES)) u_samples (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    lrgd_div #(.DIV_W(CNT_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_in),
        .i_divisor  (r_total),
        .o_done     (div_done),
        .o_grad     (div_grad)
    );

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == lrgd_pkg::ST_IDLE) && (!r_out_valid || i_m_axis_tready);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_status;

    assign ram_waddr = r_total[ADDR_W-1:0];
    assign ram_wdata = {i_s_axis_tdata[159:128], i_s_axis_tdata[FEATURES*DW-1:0]};
    assign ram_raddr = r_i[ADDR_W-1:0];
    assign tgt       = ram_q[FEATURES*DW +: DW];

    // operand selection for the shared multiplier
    always_comb begin
        x_sel = '0;
        w_sel = '0;
        for (int k = 0; k < FEATURES; k++) begin
            if (r_j == IW'(k)) begin
                x_sel = ram_q[k*DW +: DW];
                w_sel = r_w[k];
            end
        end
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            lrgd_pkg::ST_PRED: begin
                mul_a = {x_sel[DW-1], x_sel};
                mul_b = {w_sel[DW-1], w_sel};
            end
            lrgd_pkg::ST_GRAD: begin
                mul_a = {x_sel[DW-1], x_sel};
                mul_b = {r_err[DW-1], r_err};
            end
            lrgd_pkg::ST_STEP_MUL: begin
                mul_a = {div_grad[DW-1], div_grad};
                mul_b = (DW+1)'(r_lr);
            end
            default: ;
        endcase
        mul_p = mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p[AW-1:0];
    end

    always_comb begin
        div_in = (r_j == IW'(FEATURES)) ? r_acc[lrgd_pkg::BIAS_IDX] : r_acc[r_j];
        old_v  = (r_j == IW'(FEATURES)) ? r_b : w_sel;
        step   = r_prod >>> 16;
        new_v  = lrgd_pkg::sat32({{(AW-DW){old_v[DW-1]}}, old_v} - step);
    end

    always_comb begin
        n_state      = r_state;
        n_ep         = r_ep;
        n_total      = r_total;
        n_i          = r_i;
        n_j          = r_j;
        n_pred       = r_pred;
        n_err        = r_err;
        n_acc        = r_acc;
        n_w          = r_w;
        n_b          = r_b;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_data   = r_out_data;
        out_load     = 1'b0;
        out_status   = lrgd_pkg::STAT_OK;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        div_start    = 1'b0;

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            lrgd_pkg::ST_IDLE: begin
                if (accept) begin
                    out_load = 1'b1;
                    case (i_s_axis_tuser)
                        lrgd_pkg::ACT_LOAD: begin
                            if (r_total == CNT_W'(MAX_SAMPLES)) begin
                                out_status = lrgd_pkg::STAT_FULL;
                            end else begin
                                ram_we  = 1'b1;
                                n_total = r_total + 1'b1;
                            end
                        end
                        lrgd_pkg::ACT_TRAIN: begin
                            for (int k = 0; k < lrgd_pkg::NUM_W; k++) begin
                                n_w[k] = '0;
                            end
                            n_b = '0;
                            if (r_total == '0) begin
                                out_status = lrgd_pkg::STAT_EMPTY;
                            end else if (r_epochs != '0) begin
                                out_load = 1'b0;
                                n_ep     = '0;
                                n_state  = lrgd_pkg::ST_EPOCH;
                            end
                        end
                        lrgd_pkg::ACT_CLEAR: begin
                            n_total = '0;
                        end
                        default: ;
                    endcase
                end
            end
            lrgd_pkg::ST_EPOCH: begin
                for (int k = 0; k < lrgd_pkg::NUM_ACC; k++) begin
                    n_acc[k] = '0;
                end
                n_i     = '0;
                n_state = lrgd_pkg::ST_RD;
            end
            lrgd_pkg::ST_RD: begin
                ram_re  = 1'b1;
                n_pred  = {{(AW-DW){r_b[DW-1]}}, r_b};
                n_j     = '0;
                n_state = lrgd_pkg::ST_PRED;
            end
            lrgd_pkg::ST_PRED: begin
                // product of index j-1 lands while index j is issued
                if (r_j != '0) begin
                    n_pred = r_pred + (r_prod >>> 16);
                end
                n_j = r_j + 1'b1;
                if (r_j == IW'(FEATURES)) begin
                    n_state = lrgd_pkg::ST_ERR;
                end
            end
            lrgd_pkg::ST_ERR: begin
                n_err = lrgd_pkg::sat32({{(AW-DW){tgt[DW-1]}}, tgt}
                        - AW'(lrgd_pkg::sat32(r_pred)));
                n_acc[lrgd_pkg::BIAS_IDX] = r_acc[lrgd_pkg::BIAS_IDX]
                        + {{(AW-DW){n_err[DW-1]}}, n_err};
                n_j     = '0;
                n_state = lrgd_pkg::ST_GRAD;
            end
            lrgd_pkg::ST_GRAD: begin
                if (r_j != '0) begin
                    n_acc[r_j - 1'b1] = r_acc[r_j - 1'b1] + (r_prod >>> 16);
                end
                n_j = r_j + 1'b1;
                if (r_j == IW'(FEATURES)) begin
                    n_j = '0;
                    if (r_i + 1'b1 < r_total) begin
                        n_i     = r_i + 1'b1;
                        n_state = lrgd_pkg::ST_RD;
                    end else begin
                        n_state = lrgd_pkg::ST_DIV_GO;
                    end
                end
            end
            lrgd_pkg::ST_DIV_GO: begin
                div_start = 1'b1;
                n_state   = lrgd_pkg::ST_DIV_WAIT;
            end
            lrgd_pkg::ST_DIV_WAIT: begin
                if (div_done) begin
                    n_state = lrgd_pkg::ST_STEP_MUL;
                end
            end
            lrgd_pkg::ST_STEP_MUL: begin
                n_state = lrgd_pkg::ST_STEP_UPD;
            end
            lrgd_pkg::ST_STEP_UPD: begin
                if (r_j == IW'(FEATURES)) begin
                    n_b  = new_v;
                    n_j  = '0;
                    n_ep = r_ep + 1'b1;
                    if (r_ep + 1'b1 == r_epochs) begin
                        out_load = 1'b1;
                        n_state  = lrgd_pkg::ST_IDLE;
                    end else begin
                        n_state = lrgd_pkg::ST_EPOCH;
                    end
                end else begin
                    n_w[r_j[1:0]] = new_v;
                    n_j           = r_j + 1'b1;
                    n_state       = lrgd_pkg::ST_DIV_GO;
                end
            end
            default: begin
                n_state = lrgd_pkg::ST_IDLE;
            end
        endcase

        if (out_load) begin
            n_out_valid  = 1'b1;
            n_out_status = out_status;
            n_out_data   = {n_w[3], n_w[2], n_w[1], n_w[0], n_b};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lrgd_pkg::ST_IDLE;
            r_total     <= '0;
            r_out_valid <= 1'b0;
            r_b         <= '0;
            for (int k = 0; k < lrgd_pkg::NUM_W; k++) begin
                r_w[k] <= '0;
            end
            for (int k = 0; k < lrgd_pkg::NUM_ACC; k++) begin
                r_acc[k] <= '0;
            end
            r_lr        <= lrgd_pkg::LR_W'(655);
            r_epochs    <= lrgd_pkg::EPOCH_W'(1000);
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
            r_b         <= n_b;
            r_w         <= n_w;
            r_acc       <= n_acc;
            if (i_cfg_valid) begin
                if (i_cfg_index == lrgd_pkg::CFG_LEARNING_RATE) begin
                    r_lr <= i_cfg_data;
                end else if (i_cfg_index == lrgd_pkg::CFG_EPOCH_COUNT) begin
                    r_epochs <= i_cfg_data[lrgd_pkg::EPOCH_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ep         <= n_ep;
        r_i          <= n_i;
        r_j          <= n_j;
        r_pred       <= n_pred;
        r_err        <= n_err;
        r_out_status <= n_out_status;
        r_out_data   <= n_out_data;
    end
endmodule
`default_nettype wire

// ===== dv/tb_linear_regression_gradient_descent.sv =====
// Self-checking testbench for linear_regression_gradient_descent: drives loads,
// trains, clears and register writes; a scoreboard predicts every result.
// Depends on rtl/lrgd_pkg.sv and rtl/linear_regression_gradient_descent.sv.
`timescale 1ns / 100ps
`default_nettype none

module tb_linear_regression_gradient_descent;

    localparam int          STORE_DEPTH = 256;
    localparam logic [1:0]  ACT_UNUSED  = 2'd3;
    localparam logic [1:0]  CFG_SPARE_A = 2'd2;
    localparam logic [1:0]  CFG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] bias;
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
    } t_model_result;

    class trainer_scoreboard;
        int unsigned rate;
        int unsigned epochs;
        int          feat_mem [STORE_DEPTH][4];
        int          tgt_mem  [STORE_DEPTH];
        int unsigned stored;
        int          weights  [4];
        int          bias;
        t_model_result expected_q[$];
        int unsigned errors;
        int unsigned results_seen;
        int unsigned loads_done;
        int unsigned trains_done;

        function new();
            rate = 655;
            epochs = 1000;
            stored = 0;
            bias = 0;
            foreach (weights[j]) weights[j] = 0;
            errors = 0;
            results_seen = 0;
            loads_done = 0;
            trains_done = 0;
        endfunction

        function int clip(longint v);
            if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
            if (v < -64'sd2147483648) return 32'sh8000_0000;
            return int'(v);
        endfunction

        function void note_config(logic [1:0] idx, logic [16:0] data);
            if (idx == lrgd_pkg::CFG_LEARNING_RATE) rate = data;
            else if (idx == lrgd_pkg::CFG_EPOCH_COUNT) epochs = data[15:0];
        endfunction

        function void fit_model();
            longint acc [5];
            longint pred;
            longint m;
            int     err;
            int     g;
            foreach (weights[j]) weights[j] = 0;
            bias = 0;
            m = stored;
            if (m == 0) return;
            for (int e = 0; e < int'(epochs); e++) begin
                foreach (acc[j]) acc[j] = 0;
                for (int i = 0; i < int'(stored); i++) begin
                    pred = bias;
                    for (int j = 0; j < 4; j++)
                        pred += (longint'(feat_mem[i][j]) * longint'(weights[j])) >>> 16;
                    err = clip(longint'(tgt_mem[i]) - longint'(clip(pred)));
                    for (int j = 0; j < 4; j++)
                        acc[j] += (longint'(feat_mem[i][j]) * longint'(err)) >>> 16;
                    acc[4] += err;
                end
                for (int j = 0; j < 4; j++) begin
                    g = clip(-acc[j] / m);
                    weights[j] = clip(longint'(weights[j])
                                      - ((longint'(g) * longint'(rate)) >>> 16));
                end
                g = clip(-acc[4] / m);
                bias = clip(longint'(bias) - ((longint'(g) * longint'(rate)) >>> 16));
            end
        endfunction

        function void note_input(logic [1:0] act, logic [159:0] data);
            t_model_result r;
            r.status = lrgd_pkg::STAT_OK;
            if (act == lrgd_pkg::ACT_LOAD) begin
                loads_done++;
                if (stored < STORE_DEPTH) begin
                    for (int j = 0; j < 4; j++) feat_mem[stored][j] = data[32*j +: 32];
                    tgt_mem[stored] = data[128 +: 32];
                    stored++;
                end else begin
                    r.status = lrgd_pkg::STAT_FULL;
                end
            end else if (act == lrgd_pkg::ACT_TRAIN) begin
                trains_done++;
                fit_model();
                if (stored == 0) r.status = lrgd_pkg::STAT_EMPTY;
            end else if (act == lrgd_pkg::ACT_CLEAR) begin
                stored = 0;
            end
            r.bias = bias;
            r.w0 = weights[0];
            r.w1 = weights[1];
            r.w2 = weights[2];
            r.w3 = weights[3];
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [1:0] status, logic [159:0] data);
            t_model_result r;
            results_seen++;
            if (expected_q.size() == 0) begin
                $error("result with nothing expected: status %0d data %h", status, data);
                errors++;
                return;
            end
            r = expected_q.pop_front();
            if (status !== r.status) begin
                $error("status: expected %0d actual %0d", r.status, status); errors++;
            end
            if (data[31:0] !== r.bias) begin
                $error("bias_out: expected %h actual %h", r.bias, data[31:0]); errors++;
            end
            if (data[63:32] !== r.w0) begin
                $error("weight_out_0: expected %h actual %h", r.w0, data[63:32]); errors++;
            end
            if (data[95:64] !== r.w1) begin
                $error("weight_out_1: expected %h actual %h", r.w1, data[95:64]); errors++;
            end
            if (data[127:96] !== r.w2) begin
                $error("weight_out_2: expected %h actual %h", r.w2, data[127:96]); errors++;
            end
            if (data[159:128] !== r.w3) begin
                $error("weight_out_3: expected %h actual %h", r.w3, data[159:128]); errors++;
            end
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [159:0] i_s_axis_tdata;   // feature_0..feature_3, target
    logic [1:0]   i_s_axis_tuser;   // action
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    logic [159:0] o_m_axis_tdata;   // bias_out, weight_out_0..weight_out_3
    logic [1:0]   o_m_axis_tuser;   // status
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_index;
    logic [16:0]  i_cfg_data;

    trainer_scoreboard sb;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    linear_regression_gradient_descent i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // result side: random stall, check every accepted transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            if (o_m_axis_tvalid && i_m_axis_tready)
                sb.check_result(o_m_axis_tuser, o_m_axis_tdata);
        end
    end

    task automatic send_item(logic [1:0] act, int f0, int f1, int f2, int f3, int tgt);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= act;
        i_s_axis_tdata  <= {tgt, f3, f2, f1, f0};
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_input(act, {tgt, f3, f2, f1, f0});
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [16:0] data);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.note_config(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic int rand_q();
        case ($urandom_range(9))
            0, 1:    return $urandom;
            2:       return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return int'($urandom_range(524288)) - 262144;
        endcase
    endfunction

    task automatic load_random();
        send_item(lrgd_pkg::ACT_LOAD, rand_q(), rand_q(), rand_q(), rand_q(), rand_q());
    endtask

    initial begin
        int unsigned cap;
        int unsigned pick;
        sb = new();
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = lrgd_pkg::ACT_LOAD;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = lrgd_pkg::CFG_LEARNING_RATE;
        i_cfg_data      = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty store, unused code, zero and max epochs, rate extremes
        send_item(lrgd_pkg::ACT_TRAIN, 0, 0, 0, 0, 0);
        send_item(ACT_UNUSED, -1, -1, -1, -1, -1);
        write_reg(lrgd_pkg::CFG_EPOCH_COUNT, 17'd0);
        send_item(lrgd_pkg::ACT_LOAD, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, -1, 32'sh7FFF_FFFF);
        send_item(lrgd_pkg::ACT_LOAD, 32'sh8000_0000, 32'sh7FFF_FFFF, -1, 0, 32'sh8000_0000);
        send_item(lrgd_pkg::ACT_TRAIN, 0, 0, 0, 0, 0);
        send_item(lrgd_pkg::ACT_CLEAR, 0, 0, 0, 0, 0);
        write_reg(lrgd_pkg::CFG_EPOCH_COUNT, 17'd65535);
        send_item(lrgd_pkg::ACT_TRAIN, 0, 0, 0, 0, 0);
        write_reg(lrgd_pkg::CFG_EPOCH_COUNT, 17'd2);
        write_reg(lrgd_pkg::CFG_LEARNING_RATE, 17'd65536);
        send_item(lrgd_pkg::ACT_LOAD, 32'h0001_0000, 32'h0002_0000, 0, 32'hFFFF_0000,
                  32'h0003_0000);
        send_item(lrgd_pkg::ACT_LOAD, 32'h0000_8000, 0, 32'h0001_0000, 0, 32'h0001_0000);
        send_item(lrgd_pkg::ACT_LOAD, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                  32'sh8000_0000, 32'sh8000_0000);
        send_item(lrgd_pkg::ACT_TRAIN, 0, 0, 0, 0, 0);
        write_reg(lrgd_pkg::CFG_LEARNING_RATE, 17'h1FFFF);
        send_item(lrgd_pkg::ACT_TRAIN, 0, 0, 0, 0, 0);
        write_reg(lrgd_pkg::CFG_LEARNING_RATE, 17'd0);
        send_item(lrgd_pkg::ACT_TRAIN, 0, 0, 0, 0, 0);
        write_reg(CFG_SPARE_A, 17'h1FFFF);
        write_reg(CFG_SPARE_B, 17'd5);
        send_item(ACT_UNUSED, 0, 0, 0, 0, 0);

        // fill the store, overflow it, train once on the full set
        write_reg(lrgd_pkg::CFG_LEARNING_RATE, 17'd3000);
        write_reg(lrgd_pkg::CFG_EPOCH_COUNT, 17'd1);
        send_item(lrgd_pkg::ACT_CLEAR, 0, 0, 0, 0, 0);
        repeat (STORE_DEPTH) load_random();
        send_item(lrgd_pkg::ACT_LOAD, 1, 2, 3, 4, 5);
        send_item(lrgd_pkg::ACT_TRAIN, 0, 0, 0, 0, 0);
        send_item(lrgd_pkg::ACT_CLEAR, 0, 0, 0, 0, 0);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 86 : 0;
            recv_idle_pct = (phase == 0) ? 86 : (phase == 1) ? 22 : 0;
            case ($urandom_range(3))
                0:       write_reg(lrgd_pkg::CFG_LEARNING_RATE, 17'd65536);
                1:       write_reg(lrgd_pkg::CFG_LEARNING_RATE, 17'($urandom_range(131071)));
                default: write_reg(lrgd_pkg::CFG_LEARNING_RATE,
                                   17'($urandom_range(20000, 100)));
            endcase
            write_reg(lrgd_pkg::CFG_EPOCH_COUNT, 17'($urandom_range(3, 1)));
            cap = $urandom_range(24, 2);
            for (int n = 0; n < 500; n++) begin
                if (n == 250) drain();
                pick = $urandom_range(99);
                if (sb.stored >= cap) begin
                    // finish the batch: train, usually clear and start over
                    send_item(lrgd_pkg::ACT_TRAIN, rand_q(), 0, 0, 0, 0);
                    if ($urandom_range(3) != 0)
                        send_item(lrgd_pkg::ACT_CLEAR, 0, 0, 0, 0, rand_q());
                    cap = $urandom_range(24, 1);
                end else if (pick < 85) begin
                    load_random();
                end else if (pick < 92) begin
                    send_item(lrgd_pkg::ACT_TRAIN, 0, 0, 0, 0, 0);
                end else if (pick < 96) begin
                    send_item(lrgd_pkg::ACT_CLEAR, rand_q(), rand_q(), 0, 0, 0);
                end else begin
                    send_item(ACT_UNUSED, rand_q(), rand_q(), rand_q(), rand_q(), rand_q());
                end
            end
            drain();
        end

        drain();
        if (sb.expected_q.size() != 0) begin
            $error("%0d expected results never arrived", sb.expected_q.size());
            sb.errors += sb.expected_q.size();
        end
        $display("run covered %0d loads and %0d trainings, %0d results checked",
                 sb.loads_done, sb.trains_done, sb.results_seen);
        $display("rate and epoch extremes, full store, empty train and three stall mixes");
        if (sb.errors == 0) begin
            $display("** linear_regression_gradient_descent: PASSED **");
        end else begin
            $display("** linear_regression_gradient_descent: FAILED **");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("** linear_regression_gradient_descent: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
